// ----- hdl/tru_pkg.sv -----
// ----------------------------------------------------------------------------
// Threshold region uncertainty package
// Shared widths and constants for the region uncertainty block.
// ----------------------------------------------------------------------------
`default_nettype none
package tru_pkg;
  localparam int unsigned MaxVoxelsDefault = 4096;
  localparam int unsigned DoseW  = 32;
  localparam int unsigned MomW   = 64;
  localparam int unsigned VarW   = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned TotW   = 44;
  localparam int unsigned CntW   = 13;
  localparam logic [VarW-1:0] OneQ24 = 32'h0100_0000;
  localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic CfgBatch    = 1'b0;
  localparam logic CfgFraction = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/tru_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tru_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/threshold_region_uncertainty.sv -----
// ----------------------------------------------------------------------------
// Threshold region uncertainty
// Per-voxel relative variance and region mean above a dose threshold.
// ----------------------------------------------------------------------------
// Usage: pulse start with one voxel (dose, squared dose, last flag) while
// busy is low; the transaction is taken at that clock edge. busy then stays
// high through a bit-serial squarer, a bit-serial restoring divider (one
// quotient bit a cycle), the 2^24/nb term divider and the store state. A
// new voxel cannot be taken before the previous one is stored.
// On a voxel flagged last, busy stays high while the sweep reads one
// stored voxel per cycle through the RAM read port and a serial divider
// then divides the variance total by the region count. The result is on
// the result ports for exactly one cycle with valid_o high, in the cycle
// busy drops; it cannot be stalled. Configuration writes
// (cfg_valid_i/cfg_ready_o) are taken at any time; they are meant only while
// the block is idle. Reset clears counters and maximum dose and sets batch
// count 2 and fraction one half. Stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module threshold_region_uncertainty
  import tru_pkg::*;
#(
  parameter int unsigned MaxVoxels = tru_pkg::MaxVoxelsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [tru_pkg::DoseW-1:0] dose_sum_i,
  input  wire logic [tru_pkg::MomW-1:0]  dose_square_sum_i,
  input  wire logic                      last_voxel_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [tru_pkg::CfgW-1:0]  cfg_data_i,
  output logic                           valid_o,
  output logic [tru_pkg::VarW-1:0]       mean_variance_o,
  output logic [tru_pkg::CntW-1:0]       region_voxels_o,
  output logic                           empty_region_o
);
  localparam int unsigned AddrW = (MaxVoxels > 1) ? $clog2(MaxVoxels) : 1;
  localparam int unsigned VcW   = $clog2(MaxVoxels + 1);
  localparam int unsigned RcW   = VcW;

  typedef enum logic [3:0] {
    StIdle, StSquare, StDivide, StTerm, StStore, StScanRd, StScan, StScanEnd,
    StMean, StEmit
  } state_e;

  state_e state_q;
  logic [CfgW-1:0] batch_q, frac_q;
  logic [DoseW-1:0] dose_q, max_q;
  logic [MomW-1:0] mom_q;
  logic last_q;
  logic [VcW-1:0] vcount_q;
  logic [6:0] step_q;
  // squarer: shift-add, one multiplier bit per cycle
  logic [63:0] sq_q;
  logic [DoseW-1:0] mshift_q;
  // divider registers
  logic [64:0] rem_q;
  logic [88:0] quo_q;
  logic [MomW+23:0] dsh_q;
  logic sat_q;
  logic [VarW-1:0] var_q;
  // term divider: 2^24 / nb
  logic [24:0] trem_q;
  logic [24:0] tquo_q;
  // scan
  logic [AddrW-1:0] raddr_q;
  logic [VcW-1:0] scan_q;
  logic rd_valid_q;
  logic [TotW-1:0] tot_q;
  logic [RcW-1:0] rcnt_q;
  logic [47:0] limit_q;
  logic [DoseW-1:0] rd_dose;
  logic [VarW-1:0] rd_var;
  logic we;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != StIdle);
  assign we = (state_q == StStore) && (vcount_q < VcW'(MaxVoxels));

  tru_ram #(.Width(DoseW), .Depth(MaxVoxels)) u_dose_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(vcount_q[AddrW-1:0]), .wdata_i(dose_q),
    .raddr_i(raddr_q), .rdata_o(rd_dose)
  );
  tru_ram #(.Width(VarW), .Depth(MaxVoxels)) u_var_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(vcount_q[AddrW-1:0]), .wdata_i(var_q),
    .raddr_i(raddr_q), .rdata_o(rd_var)
  );

  logic [15:0] nb;
  logic [64:0] rem_sh;
  logic        rem_ge;
  logic [25:0] trem_sh;
  logic [24:0] nb25;
  logic [TotW:0] tot_add;
  logic [47:0] dose_sh;
  logic [VarW-1:0] var_fin;
  logic [33:0] q34;

  always_comb begin
    nb = (batch_q < 16'd2) ? 16'd2 : batch_q;
    nb25 = {9'd0, nb};
    rem_sh = {rem_q[63:0], dsh_q[MomW+23]};
    rem_ge = rem_sh >= {1'b0, sq_q};
    trem_sh = {trem_q, 1'b0};
    dose_sh = {rd_dose, 16'd0};
    tot_add = {1'b0, tot_q} + {{(TotW+1-VarW){1'b0}}, rd_var};
    q34 = sat_q ? 34'h2_0000_0000 : quo_q[33:0];
    if (q34 <= {9'd0, tquo_q}) var_fin = '0;
    else if ((q34 - {9'd0, tquo_q}) > 34'h0_FFFF_FFFF) var_fin = '1;
    else var_fin = 32'(q34 - {9'd0, tquo_q});
  end

  // Control and datapath sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      batch_q <= 16'd2;
      frac_q <= 16'd32768;
      max_q <= '0;
      vcount_q <= '0;
      valid_o <= 1'b0;
      rd_valid_q <= 1'b0;
      mean_variance_o <= '0;
      region_voxels_o <= '0;
      empty_region_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgBatch) batch_q <= cfg_data_i;
        else frac_q <= cfg_data_i;
      end
      unique case (state_q)
        StIdle: begin
          if (start) begin
            dose_q <= dose_sum_i;
            mom_q <= dose_square_sum_i;
            last_q <= last_voxel_i;
            mshift_q <= dose_sum_i;
            sq_q <= '0;
            step_q <= '0;
            state_q <= StSquare;
          end
        end
        StSquare: begin
          // accumulate square MSB first
          sq_q <= (sq_q << 1) + (mshift_q[DoseW-1] ? {32'd0, dose_q} : 64'd0);
          mshift_q <= mshift_q << 1;
          step_q <= step_q + 7'd1;
          if (step_q == 7'd31) begin
            step_q <= '0;
            rem_q <= '0;
            quo_q <= '0;
            sat_q <= 1'b0;
            dsh_q <= {mom_q, 24'd0};
            state_q <= StDivide;
          end
        end
        StDivide: begin
          // one quotient bit per cycle
          dsh_q <= dsh_q << 1;
          if (rem_ge) begin
            rem_q <= rem_sh - {1'b0, sq_q};
          end else begin
            rem_q <= rem_sh;
          end
          quo_q <= {quo_q[87:0], rem_ge};
          if (quo_q[88:33] != '0) sat_q <= 1'b1;
          step_q <= step_q + 7'd1;
          if (step_q == 7'd87) begin
            step_q <= '0;
            trem_q <= '0;
            tquo_q <= '0;
            state_q <= StTerm;
          end
        end
        StTerm: begin
          if (step_q == 7'd0 && (quo_q[88:33] != '0)) sat_q <= 1'b1;
          // 2^24 / nb, bits of dividend 2^24 fed MSB first
          if ({trem_sh[24:1], (step_q == 7'd0)} >= nb25) begin
            trem_q <= {trem_sh[24:1], (step_q == 7'd0)} - nb25;
            tquo_q <= {tquo_q[23:0], 1'b1};
          end else begin
            trem_q <= {trem_sh[24:1], (step_q == 7'd0)};
            tquo_q <= {tquo_q[23:0], 1'b0};
          end
          step_q <= step_q + 7'd1;
          if (step_q == 7'd24) state_q <= StStore;
        end
        StStore: begin
          if (mom_q == '0) var_q <= OneQ24;
          else if (sq_q == '0) var_q <= '1;
          else var_q <= var_fin;
          state_q <= StStore;
          if (step_q == 7'd25) begin
            step_q <= 7'd26;
          end else begin
            if (vcount_q < VcW'(MaxVoxels)) begin
              vcount_q <= vcount_q + VcW'(1);
              if (dose_q > max_q) max_q <= dose_q;
            end
            state_q <= last_q ? StScanRd : StIdle;
            raddr_q <= '0;
            scan_q <= '0;
            tot_q <= '0;
            rcnt_q <= '0;
            rd_valid_q <= 1'b0;
          end
        end
        StScanRd: begin
          limit_q <= 48'(frac_q) * 48'(max_q);
          if (vcount_q == '0) state_q <= StScanEnd;
          else begin
            raddr_q <= raddr_q + AddrW'(1);
            scan_q <= VcW'(1);
            rd_valid_q <= 1'b1;
            state_q <= StScan;
          end
        end
        StScan: begin
          // accumulate one stored voxel per cycle
          if (rd_valid_q && (dose_sh > limit_q)) begin
            rcnt_q <= rcnt_q + RcW'(1);
            tot_q <= tot_add[TotW] ? TotMax : tot_add[TotW-1:0];
          end
          if (scan_q == vcount_q) begin
            rd_valid_q <= 1'b0;
            state_q <= StScanEnd;
          end else begin
            raddr_q <= raddr_q + AddrW'(1);
            scan_q <= scan_q + VcW'(1);
          end
        end
        StScanEnd: begin
          rem_q <= '0;
          quo_q <= '0;
          dsh_q <= {tot_q, {(MomW+24-TotW){1'b0}}};
          step_q <= '0;
          state_q <= StMean;
        end
        StMean: begin
          // restoring division of the total by the region count
          dsh_q <= dsh_q << 1;
          if (rem_sh >= 65'(rcnt_q) && rcnt_q != '0) begin
            rem_q <= rem_sh - 65'(rcnt_q);
            quo_q <= {quo_q[87:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[87:0], 1'b0};
          end
          step_q <= step_q + 7'd1;
          if (step_q == 7'(TotW - 1)) state_q <= StEmit;
        end
        StEmit: begin
          valid_o <= 1'b1;
          empty_region_o <= (rcnt_q == '0);
          mean_variance_o <= (quo_q[TotW-1:VarW] != '0) ? '1 : quo_q[VarW-1:0];
          region_voxels_o <= (rcnt_q > RcW'(CntMax)) ? CntMax : CntW'(rcnt_q);
          max_q <= '0;
          vcount_q <= '0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Threshold region uncertainty testbench
// Sends voxel sets to the block under several batch and fraction settings,
// predicts the region mean variance and count per set, and checks every
// strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  logic [31:0] mean;
  logic [12:0] region;
  logic        empty;
} region_result_t;

class region_scoreboard;
  logic [15:0] batch_count;
  logic [15:0] fraction;
  logic [31:0] dose_mem [4096];
  logic [31:0] var_mem [4096];
  logic [31:0] peak_dose;
  int unsigned stored;
  region_result_t pending [$];
  int unsigned mismatches;

  function void clear_set();
    peak_dose = '0;
    stored    = 0;
  endfunction

  // Relative variance of one voxel in Q8.24
  function logic [31:0] voxel_variance(logic [31:0] d, logic [63:0] u);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quot;
    logic [63:0]  term;
    logic [15:0]  nb;
    if (u == 0) return tru_pkg::OneQ24;
    den = 128'(d) * 128'(d);
    if (den == 0) return 32'hFFFF_FFFF;
    num  = {40'b0, u, 24'b0};
    quot = num / den;
    if (quot > (128'd1 << 33)) quot = 128'd1 << 33;
    nb   = (batch_count < 2) ? 16'd2 : batch_count;
    term = 64'(tru_pkg::OneQ24) / 64'(nb);
    if (quot <= 128'(term)) return '0;
    quot = quot - 128'(term);
    if (quot > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return quot[31:0];
  endfunction

  // Note an accepted voxel; close the set on the last one
  function void note_voxel(logic [31:0] d, logic [63:0] u, logic last);
    logic [47:0]    limit;
    logic [63:0]    total;
    int unsigned    count;
    region_result_t r;
    if (stored < 4096) begin
      dose_mem[stored] = d;
      var_mem[stored]  = voxel_variance(d, u);
      if (d > peak_dose) peak_dose = d;
      stored++;
    end
    if (!last) return;
    limit = 48'(fraction) * 48'(peak_dose);
    total = '0;
    count = 0;
    for (int i = 0; i < stored; i++) begin
      if ({dose_mem[i], 16'b0} > limit) begin
        count++;
        total = total + 64'(var_mem[i]);
        if (total > 64'(tru_pkg::TotMax)) total = 64'(tru_pkg::TotMax);
      end
    end
    r.mean   = '0;
    if (count != 0) begin
      total  = total / 64'(count);
      r.mean = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    end
    r.region = (count > 8191) ? 13'h1FFF : 13'(count);
    r.empty  = (count == 0);
    pending = {pending, r};
    clear_set();
  endfunction

  // Compare one strobed result with the oldest expectation
  function void check_result(logic [31:0] mean, logic [12:0] region, logic empty);
    region_result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: mean %h region %0d empty %b", mean, region, empty);
      return;
    end
    e = pending.pop_front();
    if (mean !== e.mean || region !== e.region || empty !== e.empty) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected mean %h region %0d empty %b, %s %h region %0d empty %b",
                 e.mean, e.region, e.empty, "got mean", mean, region, empty);
    end
  endfunction
endclass

module testbench;
  import tru_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [DoseW-1:0]      dose_sum_i = '0;
  logic [MomW-1:0]       dose_square_sum_i = '0;
  logic                  last_voxel_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = CfgBatch;
  logic [CfgW-1:0]       cfg_data_i = '0;
  logic                  valid_o;
  logic [VarW-1:0]       mean_variance_o;
  logic [CntW-1:0]       region_voxels_o;
  logic                  empty_region_o;

  region_scoreboard sb;
  int unsigned      cycles = 0;

  threshold_region_uncertainty dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check each strobed result
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(mean_variance_o, region_voxels_o, empty_region_o);
  end

  // Send one voxel transaction after a random gap
  task automatic send_voxel(logic [31:0] d, logic [63:0] u, logic last);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    dose_sum_i        <= d;
    dose_square_sum_i <= u;
    last_voxel_i      <= last;
    do @(posedge clk_i); while (busy);
    sb.note_voxel(d, u, last);
  endtask

  // Wait until the block is idle, then write one register
  task automatic write_reg(logic idx, logic [15:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgBatch) sb.batch_count = value;
    else sb.fraction = value;
  endtask

  function automatic logic [31:0] pick_dose();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(1, 65535);
      5, 6:    return $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_moment(logic [31:0] d);
    logic [63:0] sq;
    sq = 64'(d) * 64'(d);
    case ($urandom_range(0, 11))
      0:       return '0;
      1, 2:    return {$urandom, $urandom};
      3:       return 64'hFFFF_FFFF_FFFF_FFFF;
      4:       return sq >> $urandom_range(1, 3);
      default: return sq + (sq >> $urandom_range(0, 24)) + 64'($urandom_range(0, 255));
    endcase
  endfunction

  // One set of random voxels closed by a last voxel
  task automatic send_set(int unsigned size);
    logic [31:0] d;
    for (int i = 0; i < size; i++) begin
      d = pick_dose();
      send_voxel(d, pick_moment(d), i == size - 1);
    end
  endtask

  initial begin
    logic [15:0] batches [6];
    logic [15:0] fracs [6];
    batches = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd2, 16'd100};
    fracs   = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd49152, 16'd16384};
    sb = new();
    sb.batch_count = 16'd2;
    sb.fraction    = 16'd32768;
    sb.clear_set();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, special variances, empty region
    send_voxel(32'h0001_0000, '0, 1'b0);                    // zero moment
    send_voxel('0, 64'h1, 1'b0);                            // zero dose, moment set
    send_voxel(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_voxel(32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0); // saturate
    send_voxel(32'h0002_0000, 64'h1_0000_0000, 1'b1);       // negative clamps
    send_voxel('0, '0, 1'b0);                               // all-zero doses
    send_voxel('0, 64'h5, 1'b1);
    send_voxel(32'h0001_0000, 64'h1_0000_0000, 1'b1);       // single voxel
    write_reg(CfgBatch, 16'd1);                             // one behaves as two
    write_reg(CfgFraction, 16'd65535);
    send_voxel(32'h0003_0000, 64'h9_8000_0000, 1'b0);
    send_voxel(32'h0003_0000, 64'h9_0000_0000, 1'b0);
    send_voxel(32'h0001_0000, 64'h2_0000_0000, 1'b1);
    write_reg(CfgFraction, 16'd0);
    send_voxel('0, 64'h7, 1'b0);                            // zero dose outside
    send_voxel(32'h8000_0000, 64'h4000_0000_0000_0000, 1'b1);

    // Random sets under several settings
    for (int p = 0; p < 8; p++) begin
      write_reg(CfgBatch, p < 6 ? batches[p] : 16'($urandom));
      write_reg(CfgFraction, p < 6 ? fracs[p] : 16'($urandom));
      for (int n = 0; n < 190; ) begin
        int unsigned size;
        size = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        send_set(size);
        n += size;
      end
    end

    // Low threshold, then a final short set
    write_reg(CfgFraction, 16'd8192);
    send_set(3);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
